FILE: src/qbv_pkg.sv
// Shared types and constants for the quaternion-between-vectors pipeline.
package qbv_pkg;

    localparam int unsigned IN_W     = 16;    // input component width
    localparam int unsigned Q_W      = 16;    // output component width
    localparam int unsigned ONE_Q14  = 16384; // 1.0 in Q1.14
    localparam int unsigned MAG_W    = 30;    // normalized magnitude width
    localparam int unsigned NORM_TOP = 29;    // leading-one position after normalizing
    localparam int unsigned QUO_W    = 15;    // quotient bits of the unit scaling
    localparam int unsigned PROD_W   = 64;    // width of |a|^2 * |b|^2
    localparam int unsigned SUMSQ_W  = 62;    // width of the normalized sum of squares

    // Geometry of one vector pair, carried alongside the first square root.
    typedef struct packed {
        logic                      degen;
        logic                      par;
        logic                      same;
        logic signed [32:0]        cx;
        logic signed [32:0]        cy;
        logic signed [32:0]        cz;
        logic signed [33:0]        dot;
        logic signed [IN_W-1:0]    ax;
        logic signed [IN_W-1:0]    ay;
        logic signed [IN_W-1:0]    az;
    } t_geo;

    // Normalized four-part vector, carried alongside the second square root.
    typedef struct packed {
        logic                      degen;
        logic [3:0]                neg;
        logic [3:0][MAG_W-1:0]     mag;
    } t_unit;

endpackage

FILE: src/quaternion_between_vectors.sv
// Top level: unit quaternion rotating one 3-D vector onto another, fully pipelined.
//
// Takes a pair of Q2.13 vectors (from, to) per transfer and returns the unit
// quaternion (x, y, z, w) in Q1.14 that turns the direction of "from" onto
// "to", plus a degenerate flag set when either vector is zero (the quaternion
// is then all zero). Same-direction pairs give the identity; opposite pairs
// give a half turn about from x X-axis (or from x Y-axis). The datapath is an
// 88-stage pipeline: 3 stages of products, a 32-stage square root of
// |a|^2|b|^2, 5 stages that select the case and normalize the scale, a
// 31-stage square root of the sum of squares, and a 17-stage four-lane divider;
// one more output register follows. One pair is taken every cycle while the
// skid entry is free. A two-entry output buffer (output register plus skid)
// holds results while the sink stalls; the whole pipeline holds only while
// the skid entry is occupied.
module quaternion_between_vectors (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // from_x, from_y, from_z, to_x, to_y, to_z (16 bits each, from bit 0 up)
    input  logic [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // quat_x, quat_y, quat_z, quat_w (16 bits each, from bit 0 up)
    output logic [63:0]  m_axis_tdata,
    // degenerate
    output logic [0:0]   m_axis_tuser
);
    import qbv_pkg::*;

    logic                 ce;

    logic                 prep_v;
    logic [PROD_W-1:0]    prep_nn;
    t_geo                 prep_geo;

    logic                 sq1_v;
    logic [31:0]          sq1_root;
    logic [$bits(t_geo)-1:0] sq1_side;

    logic                 norm_v;
    logic [SUMSQ_W-1:0]   norm_sum;
    t_unit                norm_unit;

    logic                 sq2_v;
    logic [MAG_W:0]       sq2_root;
    logic [$bits(t_unit)-1:0] sq2_side;

    logic                 div_v;
    logic [3:0][Q_W-1:0]  div_q;
    logic                 div_degen;

    logic                 r_out_v;
    logic [63:0]          r_out_data;
    logic                 r_out_user;
    logic                 r_skid_v;
    logic [63:0]          r_skid_data;
    logic                 r_skid_user;

    // advance the whole pipeline whenever the skid entry is free
    assign ce            = !r_skid_v;
    assign s_axis_tready = ce;

    qbv_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (s_axis_tvalid),
        .i_ax    (s_axis_tdata[15:0]),
        .i_ay    (s_axis_tdata[31:16]),
        .i_az    (s_axis_tdata[47:32]),
        .i_bx    (s_axis_tdata[63:48]),
        .i_by    (s_axis_tdata[79:64]),
        .i_bz    (s_axis_tdata[95:80]),
        .o_valid (prep_v),
        .o_nn    (prep_nn),
        .o_geo   (prep_geo)
    );

    // M = floor(sqrt(|a|^2 * |b|^2))
    qbv_isqrt #(
        .W  (PROD_W),
        .PW ($bits(t_geo))
    ) u_sqrt_mm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (prep_v),
        .i_rad   (prep_nn),
        .i_side  (prep_geo),
        .o_valid (sq1_v),
        .o_root  (sq1_root),
        .o_side  (sq1_side)
    );

    qbv_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (sq1_v),
        .i_root  (sq1_root),
        .i_geo   (t_geo'(sq1_side)),
        .o_valid (norm_v),
        .o_sumsq (norm_sum),
        .o_unit  (norm_unit)
    );

    // R = floor(sqrt(sum of squares)) of the normalized vector
    qbv_isqrt #(
        .W  (SUMSQ_W),
        .PW ($bits(t_unit))
    ) u_sqrt_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (norm_v),
        .i_rad   (norm_sum),
        .i_side  (norm_unit),
        .o_valid (sq2_v),
        .o_root  (sq2_root),
        .o_side  (sq2_side)
    );

    qbv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (sq2_v),
        .i_root  (sq2_root),
        .i_unit  (t_unit'(sq2_side)),
        .o_valid (div_v),
        .o_quat  (div_q),
        .o_degen (div_degen)
    );

    // Output register with skid: the pipeline end moves on each ce; a result
    // that finds the output register busy parks in the skid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (!r_out_v || m_axis_tready) begin
                if (r_skid_v) begin
                    r_out_v  <= 1'b1;
                    r_skid_v <= 1'b0;
                end else begin
                    r_out_v  <= div_v;
                end
            end else if (ce && div_v) begin
                r_skid_v <= 1'b1;
            end
        end
        if (!r_out_v || m_axis_tready) begin
            if (r_skid_v) begin
                r_out_data <= r_skid_data;
                r_out_user <= r_skid_user;
            end else begin
                r_out_data <= div_q;
                r_out_user <= div_degen;
            end
        end else if (ce && div_v) begin
            r_skid_data <= div_q;
            r_skid_user <= div_degen;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

FILE: src/qbv_prep.sv
// Front end: products, cross and dot products, and the product of squared norms.
module qbv_prep (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_ce,
    input  logic                              i_valid,
    input  logic signed [qbv_pkg::IN_W-1:0]   i_ax,
    input  logic signed [qbv_pkg::IN_W-1:0]   i_ay,
    input  logic signed [qbv_pkg::IN_W-1:0]   i_az,
    input  logic signed [qbv_pkg::IN_W-1:0]   i_bx,
    input  logic signed [qbv_pkg::IN_W-1:0]   i_by,
    input  logic signed [qbv_pkg::IN_W-1:0]   i_bz,
    output logic                              o_valid,
    output logic [qbv_pkg::PROD_W-1:0]        o_nn,
    output qbv_pkg::t_geo                     o_geo
);
    import qbv_pkg::*;

    // stage 1: all 16x16 products
    logic               r1_v;
    logic signed [31:0] r1_p [15];
    logic               r1_degen;
    logic signed [IN_W-1:0] r1_ax, r1_ay, r1_az;

    // stage 2: cross, dot, squared norms
    logic               r2_v;
    logic signed [32:0] r2_cx, r2_cy, r2_cz;
    logic signed [33:0] r2_dot;
    logic [31:0]        r2_na, r2_nb;
    logic               r2_degen;
    logic signed [IN_W-1:0] r2_ax, r2_ay, r2_az;

    // stage 3
    logic               r3_v;
    logic [PROD_W-1:0]  r3_nn;
    t_geo               r3_geo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_ce) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
        if (i_ce) begin
            r1_p[0]  <= i_ay * i_bz;
            r1_p[1]  <= i_az * i_by;
            r1_p[2]  <= i_az * i_bx;
            r1_p[3]  <= i_ax * i_bz;
            r1_p[4]  <= i_ax * i_by;
            r1_p[5]  <= i_ay * i_bx;
            r1_p[6]  <= i_ax * i_bx;
            r1_p[7]  <= i_ay * i_by;
            r1_p[8]  <= i_az * i_bz;
            r1_p[9]  <= i_ax * i_ax;
            r1_p[10] <= i_ay * i_ay;
            r1_p[11] <= i_az * i_az;
            r1_p[12] <= i_bx * i_bx;
            r1_p[13] <= i_by * i_by;
            r1_p[14] <= i_bz * i_bz;
            r1_degen <= ((i_ax == '0) && (i_ay == '0) && (i_az == '0))
                     || ((i_bx == '0) && (i_by == '0) && (i_bz == '0));
            r1_ax    <= i_ax;
            r1_ay    <= i_ay;
            r1_az    <= i_az;

            r2_cx    <= 33'(r1_p[0]) - 33'(r1_p[1]);
            r2_cy    <= 33'(r1_p[2]) - 33'(r1_p[3]);
            r2_cz    <= 33'(r1_p[4]) - 33'(r1_p[5]);
            r2_dot   <= 34'(r1_p[6]) + 34'(r1_p[7]) + 34'(r1_p[8]);
            r2_na    <= 32'(r1_p[9]) + 32'(r1_p[10]) + 32'(r1_p[11]);
            r2_nb    <= 32'(r1_p[12]) + 32'(r1_p[13]) + 32'(r1_p[14]);
            r2_degen <= r1_degen;
            r2_ax    <= r1_ax;
            r2_ay    <= r1_ay;
            r2_az    <= r1_az;

            r3_nn          <= PROD_W'(r2_na) * PROD_W'(r2_nb);
            r3_geo.degen   <= r2_degen;
            r3_geo.par     <= (r2_cx == '0) && (r2_cy == '0) && (r2_cz == '0);
            r3_geo.same    <= (r2_dot > 34'sd0);
            r3_geo.cx      <= r2_cx;
            r3_geo.cy      <= r2_cy;
            r3_geo.cz      <= r2_cz;
            r3_geo.dot     <= r2_dot;
            r3_geo.ax      <= r2_ax;
            r3_geo.ay      <= r2_ay;
            r3_geo.az      <= r2_az;
        end
    end

    assign o_valid = r3_v;
    assign o_nn    = r3_nn;
    assign o_geo   = r3_geo;

endmodule

FILE: src/qbv_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband.
module qbv_isqrt #(
    parameter int unsigned W  = 64,
    parameter int unsigned PW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_ce,
    input  logic            i_valid,
    input  logic [W-1:0]    i_rad,
    input  logic [PW-1:0]   i_side,
    output logic            o_valid,
    output logic [W/2-1:0]  o_root,
    output logic [PW-1:0]   o_side
);
    localparam int unsigned K = W / 2;

    logic           r_v    [K];
    logic [W-1:0]   r_n    [K];
    logic [W-1:0]   r_res  [K];
    logic [PW-1:0]  r_side [K];

    for (genvar k = 0; k < K; k++) begin : g_st
        localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);
        logic           v_in;
        logic [W-1:0]   n_in;
        logic [W-1:0]   res_in;
        logic [PW-1:0]  side_in;
        logic [W-1:0]   trial;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign n_in    = i_rad;
            assign res_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign n_in    = r_n[k-1];
            assign res_in  = r_res[k-1];
            assign side_in = r_side[k-1];
        end

        assign trial = res_in + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_ce) begin
                r_v[k] <= v_in;
            end
            if (i_ce) begin
                if (n_in >= trial) begin
                    r_n[k]   <= n_in - trial;
                    r_res[k] <= (res_in >> 1) + BIT;
                end else begin
                    r_n[k]   <= n_in;
                    r_res[k] <= res_in >> 1;
                end
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[K-1];
    assign o_root  = r_res[K-1][K-1:0];
    assign o_side  = r_side[K-1];

endmodule

FILE: src/qbv_norm.sv
// Build the four-part vector per case, normalize its scale, sum its squares.
module qbv_norm (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_ce,
    input  logic                           i_valid,
    input  logic [31:0]                    i_root,
    input  qbv_pkg::t_geo                  i_geo,
    output logic                           o_valid,
    output logic [qbv_pkg::SUMSQ_W-1:0]    o_sumsq,
    output qbv_pkg::t_unit                 o_unit
);
    import qbv_pkg::*;

    function automatic logic [32:0] abs16(input logic signed [IN_W-1:0] v);
        logic signed [IN_W:0] e;
        e = (IN_W+1)'(v);
        return 33'(v[IN_W-1] ? -e : e);
    endfunction

    function automatic logic [32:0] abs33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    // stage 1: case select, magnitudes and signs
    logic signed [34:0] wsum;
    logic [32:0]        n1_mag [4];
    logic [3:0]         n1_neg;

    logic               r1_v;
    logic [32:0]        r1_mag [4];
    logic [3:0]         r1_neg;
    logic               r1_degen;

    // stage 2: leading-one position
    logic [32:0]        orv;
    logic [5:0]         lead;
    logic               r2_v;
    logic [32:0]        r2_mag [4];
    logic [3:0]         r2_neg;
    logic               r2_degen;
    logic [5:0]         r2_lead;

    // stage 3..5
    logic               r3_v, r4_v, r5_v;
    t_unit              r3_unit, r4_unit, r5_unit;
    logic [2*MAG_W-1:0] r4_sq [4];
    logic [SUMSQ_W-1:0] r5_sum;

    assign wsum = 35'(i_geo.dot) + $signed({3'b000, i_root});

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n1_mag[i] = '0;
        end
        n1_neg = '0;
        priority if (i_geo.degen) begin
            n1_neg = '0;
        end else if (i_geo.par && i_geo.same) begin
            n1_mag[3] = 33'd1;
        end else if (i_geo.par) begin
            if ((i_geo.ay == '0) && (i_geo.az == '0)) begin
                n1_mag[2] = abs16(i_geo.ax);
                n1_neg[2] = i_geo.ax[IN_W-1];
            end else begin
                n1_mag[1] = abs16(i_geo.az);
                n1_neg[1] = i_geo.az[IN_W-1];
                n1_mag[2] = abs16(i_geo.ay);
                n1_neg[2] = (i_geo.ay > 16'sd0);
            end
        end else begin
            n1_mag[0] = abs33(i_geo.cx);
            n1_neg[0] = i_geo.cx[32];
            n1_mag[1] = abs33(i_geo.cy);
            n1_neg[1] = i_geo.cy[32];
            n1_mag[2] = abs33(i_geo.cz);
            n1_neg[2] = i_geo.cz[32];
            // clamp a negative scalar part to zero
            n1_mag[3] = wsum[34] ? '0 : wsum[32:0];
        end
    end

    assign orv = r1_mag[0] | r1_mag[1] | r1_mag[2] | r1_mag[3];

    always_comb begin
        lead = '0;
        for (int i = 0; i < 33; i++) begin
            if (orv[i]) begin
                lead = 6'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (i_ce) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
        if (i_ce) begin
            r1_mag   <= n1_mag;
            r1_neg   <= n1_neg;
            r1_degen <= i_geo.degen;

            r2_mag   <= r1_mag;
            r2_neg   <= r1_neg;
            r2_degen <= r1_degen;
            r2_lead  <= lead;

            for (int i = 0; i < 4; i++) begin
                if (r2_lead >= 6'(NORM_TOP)) begin
                    r3_unit.mag[i] <= MAG_W'(r2_mag[i] >> (r2_lead - 6'(NORM_TOP)));
                end else begin
                    r3_unit.mag[i] <= MAG_W'(r2_mag[i] << (6'(NORM_TOP) - r2_lead));
                end
            end
            r3_unit.neg   <= r2_neg;
            r3_unit.degen <= r2_degen;

            for (int i = 0; i < 4; i++) begin
                r4_sq[i] <= (2*MAG_W)'(r3_unit.mag[i]) * (2*MAG_W)'(r3_unit.mag[i]);
            end
            r4_unit <= r3_unit;

            r5_sum  <= SUMSQ_W'(r4_sq[0]) + SUMSQ_W'(r4_sq[1])
                     + SUMSQ_W'(r4_sq[2]) + SUMSQ_W'(r4_sq[3]);
            r5_unit <= r4_unit;
        end
    end

    assign o_valid = r5_v;
    assign o_sumsq = r5_sum;
    assign o_unit  = r5_unit;

endmodule

FILE: src/qbv_div.sv
// Four-lane restoring divider: part = round(mag * 2^14 / r), capped and signed.
module qbv_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_ce,
    input  logic                               i_valid,
    input  logic [qbv_pkg::MAG_W:0]            i_root,
    input  qbv_pkg::t_unit                     i_unit,
    output logic                               o_valid,
    output logic [3:0][qbv_pkg::Q_W-1:0]       o_quat,
    output logic                               o_degen
);
    import qbv_pkg::*;

    localparam int unsigned NUM_W = MAG_W + 15;

    logic               r0_v;
    logic [NUM_W-1:0]   r0_num [4];
    logic [MAG_W:0]     r0_root;
    logic [3:0]         r0_neg;
    logic               r0_degen;

    logic               r_v     [QUO_W];
    logic [NUM_W-1:0]   r_num   [QUO_W][4];
    logic [QUO_W-1:0]   r_quo   [QUO_W][4];
    logic [MAG_W:0]     r_root  [QUO_W];
    logic [3:0]         r_neg   [QUO_W];
    logic               r_degen [QUO_W];

    logic               r_out_v;
    logic [3:0][Q_W-1:0] r_out_q;
    logic               r_out_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_ce) begin
            r0_v <= i_valid;
        end
        if (i_ce) begin
            for (int i = 0; i < 4; i++) begin
                r0_num[i] <= {1'b0, i_unit.mag[i], 14'b0} + NUM_W'(i_root >> 1);
            end
            r0_root  <= i_root;
            r0_neg   <= i_unit.neg;
            r0_degen <= i_unit.degen;
        end
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_st
        localparam int unsigned SH = QUO_W - 1 - j;
        logic               v_in;
        logic [NUM_W-1:0]   num_in [4];
        logic [QUO_W-1:0]   quo_in [4];
        logic [MAG_W:0]     root_in;
        logic [3:0]         neg_in;
        logic               degen_in;
        logic [NUM_W:0]     trial;

        if (j == 0) begin : g_first
            assign v_in     = r0_v;
            assign num_in   = r0_num;
            assign quo_in   = '{default: '0};
            assign root_in  = r0_root;
            assign neg_in   = r0_neg;
            assign degen_in = r0_degen;
        end else begin : g_next
            assign v_in     = r_v[j-1];
            assign num_in   = r_num[j-1];
            assign quo_in   = r_quo[j-1];
            assign root_in  = r_root[j-1];
            assign neg_in   = r_neg[j-1];
            assign degen_in = r_degen[j-1];
        end

        assign trial = (NUM_W+1)'(root_in) << SH;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_ce) begin
                r_v[j] <= v_in;
            end
            if (i_ce) begin
                for (int i = 0; i < 4; i++) begin
                    if ({1'b0, num_in[i]} >= trial) begin
                        r_num[j][i]     <= NUM_W'({1'b0, num_in[i]} - trial);
                        r_quo[j][i]     <= quo_in[i] | (QUO_W'(1) << SH);
                    end else begin
                        r_num[j][i]     <= num_in[i];
                        r_quo[j][i]     <= quo_in[i];
                    end
                end
                r_root[j]  <= root_in;
                r_neg[j]   <= neg_in;
                r_degen[j] <= degen_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [QUO_W-1:0] capped;
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_ce) begin
            r_out_v <= r_v[QUO_W-1];
        end
        if (i_ce) begin
            for (int i = 0; i < 4; i++) begin
                capped = (r_quo[QUO_W-1][i] > QUO_W'(ONE_Q14)) ? QUO_W'(ONE_Q14)
                                                               : r_quo[QUO_W-1][i];
                if (r_degen[QUO_W-1]) begin
                    r_out_q[i] <= '0;
                end else if (r_neg[QUO_W-1][i]) begin
                    r_out_q[i] <= Q_W'(-{1'b0, capped});
                end else begin
                    r_out_q[i] <= Q_W'({1'b0, capped});
                end
            end
            r_out_degen <= r_degen[QUO_W-1];
        end
    end

    assign o_valid = r_out_v;
    assign o_quat  = r_out_q;
    assign o_degen = r_out_degen;

endmodule

FILE: src/qbv_checker.sv
// Port-level checks for the quaternion-between-vectors block, bound to the top level.
module qbv_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [63:0]  m_axis_tdata,
    input  logic [0:0]   m_axis_tuser
);
    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // a degenerate pair carries an all-zero quaternion
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 64'd0)
        else $error("degenerate result not zero");

    // input side backs off only after the output stalled
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output stall");

    // unit quaternion parts stay within plus or minus one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            $signed(m_axis_tdata[15:0])  <= 16'sd16384 && $signed(m_axis_tdata[15:0])  >= -16'sd16384 &&
            $signed(m_axis_tdata[31:16]) <= 16'sd16384 && $signed(m_axis_tdata[31:16]) >= -16'sd16384 &&
            $signed(m_axis_tdata[47:32]) <= 16'sd16384 && $signed(m_axis_tdata[47:32]) >= -16'sd16384 &&
            $signed(m_axis_tdata[63:48]) <= 16'sd16384 && $signed(m_axis_tdata[63:48]) >= -16'sd16384)
        else $error("quaternion part out of range");

endmodule

bind quaternion_between_vectors qbv_checker u_qbv_checker (.*);
